@@ rtl/psd_pkg.sv @@
// Shared types and constants for the program stream audio track demultiplexer.
`timescale 1ns / 1ps

package psd_pkg;

   localparam int ByteW   = 8;
   localparam int TrackW  = 3;
   localparam int StatusW = 3;

   // Status codes carried with a result.
   localparam logic [StatusW-1:0] STAT_NONE     = 3'd0;
   localparam logic [StatusW-1:0] STAT_END      = 3'd1;
   localparam logic [StatusW-1:0] STAT_NO_PACK  = 3'd2;
   localparam logic [StatusW-1:0] STAT_BAD_END  = 3'd3;
   localparam logic [StatusW-1:0] STAT_TRUNC    = 3'd4;
   localparam logic [StatusW-1:0] STAT_BAD_HLEN = 3'd5;

   // Start codes and stream ids.
   localparam logic [31:0] PACK_START_CODE  = 32'h0000_01ba;
   localparam logic [31:0] PROGRAM_END_CODE = 32'h0000_01b9;
   localparam logic [23:0] START_PREFIX     = 24'h00_0001;
   localparam logic [7:0]  PRIVATE_STREAM_1 = 8'hbd;
   localparam logic [7:0]  SUBSTREAM_BASE   = 8'h80;

   // One parsed byte's outcome.
   typedef struct packed {
      logic               has_result;
      logic               payload_valid;
      logic [ByteW-1:0]   payload_byte;
      logic [StatusW-1:0] status;
   } result_type;

endpackage

@@ rtl/psd_parser.sv @@
// Byte parser: parse state registers and the per-byte next-state logic.
`timescale 1ns / 1ps

module psd_parser
   import psd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic [ByteW-1:0]  data_byte,
   input  logic              is_last,
   input  logic [TrackW-1:0] track_select,
   output result_type        result
);

   localparam logic [2:0] PH_START    = 3'd0;
   localparam logic [2:0] PH_PACK     = 3'd1;
   localparam logic [2:0] PH_LOOK     = 3'd2;
   localparam logic [2:0] PH_PES_HEAD = 3'd3;
   localparam logic [2:0] PH_PRIV     = 3'd4;
   localparam logic [2:0] PH_SKIP     = 3'd5;
   localparam logic [2:0] PH_DONE     = 3'd6;

   logic [2:0]  phase_ff,   phase_in;
   logic [31:0] recent_ff,  recent_in;
   logic [8:0]  index_ff,   index_in;
   logic [15:0] left_ff,    left_in;
   logic [15:0] plen_ff,    plen_in;
   logic [7:0]  hlen_ff,    hlen_in;
   logic [7:0]  sid_ff,     sid_in;
   logic        emit_ff,    emit_in;

   logic [31:0]        shifted;
   logic [15:0]        plen_full;
   logic [15:0]        left_dec;
   logic [8:0]         tag_index;
   logic [8:0]         data_index;
   logic [8:0]         need_len;
   logic [7:0]         substream;
   logic               pay_valid;
   logic [StatusW-1:0] status;

   always_comb begin
      shifted    = {recent_ff[23:0], data_byte};
      plen_full  = {plen_ff[15:8], data_byte};
      left_dec   = (left_ff != 16'd0) ? left_ff - 16'd1 : left_ff;
      tag_index  = {1'b0, hlen_ff} + 9'd9;
      data_index = {1'b0, hlen_ff} + 9'd13;
      need_len   = {1'b0, data_byte} + 9'd7;
      substream  = SUBSTREAM_BASE + {5'd0, track_select};

      phase_in  = phase_ff;
      recent_in = recent_ff;
      index_in  = index_ff;
      left_in   = left_ff;
      plen_in   = plen_ff;
      hlen_in   = hlen_ff;
      sid_in    = sid_ff;
      emit_in   = emit_ff;
      pay_valid = 1'b0;
      status    = STAT_NONE;

      case (phase_ff)
         PH_START, PH_LOOK: begin
            recent_in = shifted;
            index_in  = index_ff + 9'd1;
            if (index_ff >= 9'd3) begin
               if (shifted == PACK_START_CODE) begin
                  phase_in = PH_PACK;
                  index_in = 9'd4;
               end else if (phase_ff == PH_START) begin
                  status = STAT_NO_PACK;
               end else if (shifted == PROGRAM_END_CODE) begin
                  status = STAT_END;
               end else if (shifted[31:8] == START_PREFIX) begin
                  sid_in   = shifted[7:0];
                  phase_in = PH_PES_HEAD;
                  index_in = 9'd4;
               end else begin
                  status = STAT_BAD_END;
               end
            end
         end
         PH_PACK: begin
            if (index_ff >= 9'd13) begin
               // Last pack header byte: its low bits count the stuffing bytes.
               left_in = {13'd0, data_byte[2:0]};
               if (data_byte[2:0] == 3'd0) begin
                  phase_in = PH_LOOK;
                  index_in = 9'd0;
               end else begin
                  phase_in = PH_SKIP;
               end
            end else begin
               index_in = index_ff + 9'd1;
            end
         end
         PH_PES_HEAD: begin
            if (index_ff == 9'd4) begin
               plen_in  = {data_byte, 8'h00};
               index_in = index_ff + 9'd1;
            end else if (index_ff == 9'd5) begin
               plen_in = plen_full;
               if (sid_ff != PRIVATE_STREAM_1) begin
                  left_in = plen_full;
                  if (plen_full == 16'd0) begin
                     phase_in = PH_LOOK;
                     index_in = 9'd0;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end else if (plen_full < 16'd3) begin
                  status = STAT_BAD_HLEN;
               end else begin
                  index_in = index_ff + 9'd1;
               end
            end else if (index_ff >= 9'd8) begin
               hlen_in = data_byte;
               if ({7'd0, need_len} > plen_ff) begin
                  status = STAT_BAD_HLEN;
               end else begin
                  left_in  = plen_ff - 16'd3;
                  emit_in  = 1'b0;
                  phase_in = PH_PRIV;
                  index_in = index_ff + 9'd1;
               end
            end else begin
               index_in = index_ff + 9'd1;
            end
         end
         PH_PRIV: begin
            if (index_ff == tag_index) begin
               emit_in = (data_byte == substream);
            end else if (index_ff >= data_index && emit_ff) begin
               pay_valid = 1'b1;
            end
            if (index_ff != 9'h1ff) begin
               index_in = index_ff + 9'd1;
            end
            left_in = left_dec;
            if (left_dec == 16'd0) begin
               phase_in = PH_LOOK;
               index_in = 9'd0;
            end
         end
         PH_SKIP: begin
            left_in = left_dec;
            if (left_dec == 16'd0) begin
               phase_in = PH_LOOK;
               index_in = 9'd0;
            end
         end
         default: begin
         end
      endcase

      // Any final byte that closes nothing else reports truncation.
      if (phase_ff != PH_DONE) begin
         if (status == STAT_NONE && is_last) begin
            status = STAT_TRUNC;
         end
         if (status != STAT_NONE) begin
            phase_in = PH_DONE;
         end
      end

      result.has_result    = pay_valid || (status != STAT_NONE);
      result.payload_valid = pay_valid;
      result.payload_byte  = pay_valid ? data_byte : 8'h00;
      result.status        = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         recent_ff <= '0;
         index_ff  <= '0;
         left_ff   <= '0;
         plen_ff   <= '0;
         hlen_ff   <= '0;
         sid_ff    <= '0;
         emit_ff   <= 1'b0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         recent_ff <= recent_in;
         index_ff  <= index_in;
         left_ff   <= left_in;
         plen_ff   <= plen_in;
         hlen_ff   <= hlen_in;
         sid_ff    <= sid_in;
         emit_ff   <= emit_in;
      end
   end

endmodule

@@ rtl/program_stream_ac3_track_demux.sv @@
// Top level of the program stream audio track demultiplexer.
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_stall  req_data_byte, req_is_last
//   rsp       out        rsp_valid / rsp_stall  rsp_payload_valid, rsp_payload_byte, rsp_status
//   csr       in         csr_wr_en              csr_wr_data (track select)
//
// One byte per cycle while results are not stalled: a byte is held in the input
// register, and its parse step writes the result register, so each result passes
// through both registers.  The per-byte parse step sets the rate.
// Reset is synchronous and clears the parse state and the track select, and
// empties both registers.  A held result stalls the parse step; the input register
// still takes one more byte, after which req_stall rises.
`timescale 1ns / 1ps

module program_stream_ac3_track_demux
   import psd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [ByteW-1:0]   req_data_byte,
   input  logic               req_is_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_payload_valid,
   output logic [ByteW-1:0]   rsp_payload_byte,
   output logic [StatusW-1:0] rsp_status,
   input  logic               csr_wr_en,
   input  logic [TrackW-1:0]  csr_wr_data
);

   logic [TrackW-1:0] track_ff;
   logic              in_valid_ff, in_valid_in;
   logic [ByteW-1:0]  in_byte_ff;
   logic              in_last_ff;
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff;
   result_type        result;
   logic              advance;
   logic              req_take;

   // The buffered byte moves on whenever the result register can take a result.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance && result.has_result) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   psd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .data_byte    (in_byte_ff),
      .is_last      (in_last_ff),
      .track_select (track_ff),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         track_ff     <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            track_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_is_last;
      end
      if (advance && result.has_result) begin
         out_ff <= result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_payload_valid = out_ff.payload_valid;
   assign rsp_payload_byte  = out_ff.payload_byte;
   assign rsp_status        = out_ff.status;

endmodule

@@ rtl/psd_checker.sv @@
// Port-level checks for the demultiplexer, bound to its top level.
`timescale 1ns / 1ps

module psd_checker
   import psd_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_payload_valid,
   input logic [ByteW-1:0]   rsp_payload_byte,
   input logic [StatusW-1:0] rsp_status
);

   // A stalled result holds until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload_byte)
         && $stable(rsp_status) && $stable(rsp_payload_valid))
      else $error("result changed while stalled");

   // A result without a status always carries a payload byte.
   a_rsp_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_NONE |-> rsp_payload_valid)
      else $error("empty result presented");

   // With no payload the byte field reads zero.
   a_rsp_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload_valid |-> rsp_payload_byte == 8'h00)
      else $error("payload byte set without payload");

   // A status result is the last one until reset.
   a_rsp_after_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_status != STAT_NONE |=> !rsp_valid)
      else $error("result after a final status");

endmodule

bind program_stream_ac3_track_demux psd_checker u_psd_checker (.*);
